// ===== src/char_lcd_nibble_writer_assert.svh =====
// Assertion helpers for the char_lcd_nibble_writer modules (used in clcd_back).
// Each expects signals named clock and reset in the enclosing module.
`ifndef CHAR_LCD_NIBBLE_WRITER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITER_ASSERT_SVH

// Same-cycle implication.
`define CLCD_ASSERT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("char_lcd_nibble_writer: check failed");

// Next-cycle implication.
`define CLCD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("char_lcd_nibble_writer: check failed");

`endif

// ===== src/clcd_pkg.sv =====
`timescale 1ns / 1ps
package clcd_pkg;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] value;
      logic [5:0] column;
      logic [1:0] row;
      logic [6:0] cursor_address;
   } req_type;

   typedef struct packed {
      logic       reg_select;
      logic [3:0] nibble;
      logic       timed_only;
      logic       last;
   } rsp_type;

   localparam logic [2:0] FUNC_INIT = 3'd0;
   localparam logic [2:0] FUNC_PUT  = 3'd1;
   localparam logic [2:0] FUNC_CMD  = 3'd2;
   localparam logic [2:0] FUNC_DATA = 3'd3;
   localparam logic [2:0] FUNC_GOTO = 3'd4;

   localparam logic [2:0] CSR_LINE_COUNT  = 3'd0;
   localparam logic [2:0] CSR_LINE1_START = 3'd1;
   localparam logic [2:0] CSR_LINE2_START = 3'd2;
   localparam logic [2:0] CSR_LINE3_START = 3'd3;
   localparam logic [2:0] CSR_LINE4_START = 3'd4;
   localparam logic [2:0] CSR_LINE_LENGTH = 3'd5;
   localparam logic [2:0] CSR_WRAP_ENABLE = 3'd6;

   localparam logic [2:0] LINES_ONE = 3'd1;
   localparam logic [2:0] LINES_TWO = 3'd2;

   // job kinds queued between front and back
   localparam logic [1:0] JOB_INIT = 2'd0;
   localparam logic [1:0] JOB_ONE  = 2'd1;
   localparam logic [1:0] JOB_TWO  = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] first_byte;
      logic       first_rs;
      logic [7:0] second_byte;
      logic       second_rs;
   } job_type;

   localparam logic [7:0] CMD_SET_ADDR    = 8'h80;
   localparam logic [7:0] CMD_FUNC_1LINE  = 8'h20;
   localparam logic [7:0] CMD_FUNC_NLINE  = 8'h28;
   localparam logic [7:0] CMD_DISPLAY_OFF = 8'h08;
   localparam logic [7:0] CMD_CLEAR       = 8'h01;
   localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [3:0] NIB_WAKE        = 4'h3;
   localparam logic [3:0] NIB_4BIT        = 4'h2;

   // sequencer step positions
   localparam logic [3:0] STEP_WAKE_LAST = 4'd3;
   localparam logic [3:0] STEP_INIT_BYTES = 4'd4;
   localparam logic [3:0] STEP_INIT_LAST = 4'd13;
   localparam logic [3:0] STEP_PAIR_LAST = 4'd3;
   localparam logic [3:0] STEP_ONE_FIRST = 4'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== src/clcd_queue.sv =====
`timescale 1ns / 1ps
module clcd_queue import clcd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type job_in,
   input  logic    pop,
   output job_type job_out,
   output logic    full,
   output logic    empty
);

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign job_out = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

// ===== src/clcd_front.sv =====
`timescale 1ns / 1ps
module clcd_front import clcd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [6:0] csr_data,
   input  logic       q_full,
   output logic       push,
   output job_type    job
);

   logic [2:0] line_count_ff;
   logic [6:0] line1_start_ff, line2_start_ff, line3_start_ff, line4_start_ff;
   logic [6:0] line_length_ff;
   logic       wrap_enable_ff;

   logic       mode_one, mode_two;
   logic [6:0] pos;
   logic [6:0] newline_addr;
   logic [7:0] end1, end2, end3, end4;
   logic       hit1, hit2, hit3, hit4;
   logic       wrap_hit;
   logic [6:0] wrap_next;
   logic [6:0] goto_start;
   logic       func_known;

   assign csr_ready = 1'b1;
   assign req_ready = !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff  <= 3'd2;
         line1_start_ff <= 7'd0;
         line2_start_ff <= 7'd64;
         line3_start_ff <= 7'd20;
         line4_start_ff <= 7'd84;
         line_length_ff <= 7'd16;
         wrap_enable_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LINE_COUNT:  line_count_ff  <= csr_data[2:0];
            CSR_LINE1_START: line1_start_ff <= csr_data;
            CSR_LINE2_START: line2_start_ff <= csr_data;
            CSR_LINE3_START: line3_start_ff <= csr_data;
            CSR_LINE4_START: line4_start_ff <= csr_data;
            CSR_LINE_LENGTH: line_length_ff <= csr_data;
            CSR_WRAP_ENABLE: wrap_enable_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   assign mode_one = (line_count_ff == LINES_ONE);
   assign mode_two = (line_count_ff == LINES_TWO);
   assign pos      = req_data.cursor_address;

   always_comb begin
      if (mode_one) begin
         newline_addr = 7'd0;
      end else if (mode_two) begin
         newline_addr = (pos < line2_start_ff) ? line2_start_ff : line1_start_ff;
      end else if (pos < line3_start_ff) begin
         newline_addr = line2_start_ff;
      end else if (pos >= line2_start_ff && pos < line4_start_ff) begin
         newline_addr = line3_start_ff;
      end else if (pos >= line3_start_ff && pos < line2_start_ff) begin
         newline_addr = line4_start_ff;
      end else begin
         newline_addr = line1_start_ff;
      end
   end

   // line ends compared at full width, no truncation
   assign end1 = {1'b0, line1_start_ff} + {1'b0, line_length_ff};
   assign end2 = {1'b0, line2_start_ff} + {1'b0, line_length_ff};
   assign end3 = {1'b0, line3_start_ff} + {1'b0, line_length_ff};
   assign end4 = {1'b0, line4_start_ff} + {1'b0, line_length_ff};
   assign hit1 = ({1'b0, pos} == end1);
   assign hit2 = ({1'b0, pos} == end2) && !mode_one;
   assign hit3 = ({1'b0, pos} == end3) && !mode_one && !mode_two;
   assign hit4 = ({1'b0, pos} == end4) && !mode_one && !mode_two;
   assign wrap_hit = hit1 || hit2 || hit3 || hit4;

   always_comb begin
      if (hit1) begin
         wrap_next = mode_one ? line1_start_ff : line2_start_ff;
      end else if (hit2) begin
         wrap_next = mode_two ? line1_start_ff : line3_start_ff;
      end else if (hit3) begin
         wrap_next = line4_start_ff;
      end else begin
         wrap_next = line1_start_ff;
      end
   end

   always_comb begin
      if (mode_one || req_data.row == 2'd0) begin
         goto_start = line1_start_ff;
      end else if (mode_two || req_data.row == 2'd1) begin
         goto_start = line2_start_ff;
      end else if (req_data.row == 2'd2) begin
         goto_start = line3_start_ff;
      end else begin
         goto_start = line4_start_ff;
      end
   end

   always_comb begin
      job             = '0;
      job.kind        = JOB_ONE;
      job.second_byte = req_data.value;
      func_known      = 1'b1;
      case (req_data.func)
         FUNC_INIT: begin
            job.kind       = JOB_INIT;
            job.first_byte = mode_one ? CMD_FUNC_1LINE : CMD_FUNC_NLINE;
         end
         FUNC_PUT: begin
            if (req_data.value == CHAR_NEWLINE) begin
               job.second_byte = {1'b1, newline_addr};
            end else begin
               job.second_rs = 1'b1;
               if (wrap_enable_ff && wrap_hit) begin
                  job.kind       = JOB_TWO;
                  job.first_byte = {1'b1, wrap_next};
               end
            end
         end
         FUNC_CMD: begin
         end
         FUNC_DATA: begin
            job.second_rs = 1'b1;
         end
         FUNC_GOTO: begin
            job.second_byte = CMD_SET_ADDR + {1'b0, goto_start} + {2'b0, req_data.column};
         end
         default: begin
            // undefined codes are taken and dropped
            func_known = 1'b0;
         end
      endcase
   end

   assign push = req_valid && req_ready && func_known;

endmodule

// ===== src/clcd_back.sv =====
`timescale 1ns / 1ps
`include "char_lcd_nibble_writer_assert.svh"
module clcd_back import clcd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  job_type head,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic       active_ff, active_in;
   logic [3:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic       is_init;
   logic [3:0] cur_step;
   logic [3:0] init_idx;
   logic [7:0] cur_byte;
   logic       advance;
   rsp_type    nib;

   assign is_init  = (head.kind == JOB_INIT);
   assign cur_step = active_ff ? step_ff : ((head.kind == JOB_ONE) ? STEP_ONE_FIRST : 4'd0);
   assign init_idx = cur_step - STEP_INIT_BYTES;

   always_comb begin
      nib      = '0;
      cur_byte = head.second_byte;
      if (is_init) begin
         case (init_idx[3:1])
            3'd0:    cur_byte = head.first_byte;
            3'd1:    cur_byte = CMD_DISPLAY_OFF;
            3'd2:    cur_byte = CMD_CLEAR;
            3'd3:    cur_byte = CMD_ENTRY_MODE;
            default: cur_byte = head.second_byte;
         endcase
         if (cur_step <= STEP_WAKE_LAST) begin
            nib.timed_only = 1'b1;
            nib.nibble     = (cur_step == STEP_WAKE_LAST) ? NIB_4BIT : NIB_WAKE;
         end else begin
            nib.nibble = init_idx[0] ? cur_byte[3:0] : cur_byte[7:4];
         end
         nib.last = (cur_step == STEP_INIT_LAST);
      end else begin
         cur_byte       = cur_step[1] ? head.second_byte : head.first_byte;
         nib.reg_select = cur_step[1] ? head.second_rs : head.first_rs;
         nib.nibble     = cur_step[0] ? cur_byte[3:0] : cur_byte[7:4];
         nib.last       = (cur_step == STEP_PAIR_LAST);
      end
   end

   // advance when a job is queued and the output slot is free or being emptied this cycle
   assign advance = !q_empty && (!rsp_valid_ff || rsp_ready);
   assign pop     = advance && nib.last;

   always_comb begin
      active_in    = active_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         active_in    = !nib.last;
         step_in      = cur_step + 1'b1;
         rsp_valid_in = 1'b1;
         rsp_data_in  = nib;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `CLCD_ASSERT(a_timed_not_last, rsp_valid_ff && rsp_data_ff.timed_only, !rsp_data_ff.last)
   `CLCD_ASSERT(a_active_has_job, active_ff, !q_empty)
   `CLCD_ASSERT(a_step_range, active_ff, step_ff <= STEP_INIT_LAST)
   `CLCD_ASSERT_NEXT(a_pop_ends_job, pop, !active_ff && rsp_valid_ff && rsp_data_ff.last)

endmodule

// ===== src/char_lcd_nibble_writer.sv =====
`timescale 1ns / 1ps
// Host-side request encoder for a 4-bit character LCD bus.
// req_* : one request per handshake (initialise, put character, command,
//         data, go to position); req_data carries func, value, column, row
//         and the cursor address last read back from the display.
// rsp_* : one enable-pulse nibble per handshake, high nibble first, with its
//         register select, a timed-only flag for the wake-up nibbles and a
//         last flag on the final nibble of each request.
// csr_* : register writes (line count, four line starts, line length, wrap),
//         always ready; write only while no request is in flight.
// A taken request is written into the job queue; nibbles leave through a registered output stage.
// The back-end sequencer issues one nibble per cycle while rsp_ready is not
// stalled; a request yields 2 nibbles (command, data, go to, plain put),
// 4 (put with wrap) or 14 (initialise). Undefined func codes are taken and produce nothing.
// A two-entry job queue sits between the classifier and the sequencer, so
// req_ready stays high while the output side works off earlier requests.
// A stalled rsp_ready holds the current nibble; new requests are taken until
// the queue is full. Synchronous reset empties the queue and output stage
// and restores the register defaults.
module char_lcd_nibble_writer import clcd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [6:0] csr_data
);

   logic    q_full, q_empty, push, pop;
   job_type job_in, job_head;

   clcd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_full    (q_full),
      .push      (push),
      .job       (job_in)
   );

   clcd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .job_in  (job_in),
      .pop     (pop),
      .job_out (job_head),
      .full    (q_full),
      .empty   (q_empty)
   );

   clcd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .head      (job_head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
